### rtl/serial_frame_receiver_defines.svh
// assertion macros for the receiver rtl
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define SFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sfr assertion failed");
// checked on every clock edge, reset included
`define SFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT(lbl, prop)
`define SFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### rtl/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned IdxW  = 6;

  // expected header and tail bytes
  typedef struct packed {
    logic [ByteW-1:0] head_first;
    logic [ByteW-1:0] head_second;
    logic [ByteW-1:0] tail_first;
    logic [ByteW-1:0] tail_second;
  } sfr_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic cap_ident;
    logic cap_len;
    logic wr_data;
    logic cap_chk0;
    logic cap_chk1;
    logic emit_start;
    logic rd_en;
    logic load_out;
    logic emit_next;
  } sfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head0_hit;
    logic head1_hit;
    logic tail0_hit;
    logic tail1_hit;
    logic len_zero;
    logic len_big;
    logic fill_done;
    logic emit_last;
    logic out_free;
  } sfr_sts_t;

endpackage

### rtl/sfr_dp.sv
module sfr_dp #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sfr_pkg::sfr_cfg_t                  cfg_i,
  input  sfr_pkg::sfr_cmd_t                  cmd_i,
  output sfr_pkg::sfr_sts_t                  sts_o,
  input  logic [sfr_pkg::ByteW-1:0]          rx_byte_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [sfr_pkg::ByteW-1:0]          frame_ident_o,
  output logic [sfr_pkg::LenW-1:0]           payload_length_o,
  output logic [sfr_pkg::IdxW-1:0]           byte_index_o,
  output logic [sfr_pkg::ByteW-1:0]          payload_byte_o,
  output logic                               byte_valid_o,
  output logic [sfr_pkg::ByteW-1:0]          check_first_o,
  output logic [sfr_pkg::ByteW-1:0]          check_second_o,
  output logic                               last_of_frame_o
);
  import sfr_pkg::*;

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [ByteW-1:0] MaxLen = ByteW'(MAX_PAYLOAD);

  logic [ByteW-1:0] ident_q;
  logic [LenW-1:0]  length_q;
  logic [LenW-1:0]  fill_q;
  logic [LenW-1:0]  fill_inc;
  logic [ByteW-1:0] chk0_q;
  logic [ByteW-1:0] chk1_q;
  logic [IdxW-1:0]  emit_idx_q;
  logic [LenW-1:0]  emit_inc;
  logic [ByteW-1:0] rd_data_q;
  logic [ByteW-1:0] mem_q [MAX_PAYLOAD];
  logic             len_nz;

  logic             out_valid_q;
  logic [ByteW-1:0] out_ident_q;
  logic [LenW-1:0]  out_len_q;
  logic [IdxW-1:0]  out_idx_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_bvalid_q;
  logic [ByteW-1:0] out_chk0_q;
  logic [ByteW-1:0] out_chk1_q;
  logic             out_last_q;

  assign fill_inc = fill_q + LenW'(1);
  assign emit_inc = {1'b0, emit_idx_q} + LenW'(1);
  assign len_nz   = (length_q != '0);

  always_comb begin
    sts_o.head0_hit = (rx_byte_i == cfg_i.head_first);
    sts_o.head1_hit = (rx_byte_i == cfg_i.head_second);
    sts_o.tail0_hit = (rx_byte_i == cfg_i.tail_first);
    sts_o.tail1_hit = (rx_byte_i == cfg_i.tail_second);
    sts_o.len_zero  = (rx_byte_i == '0);
    sts_o.len_big   = (rx_byte_i > MaxLen);
    sts_o.fill_done = (fill_inc >= length_q);
    sts_o.emit_last = !len_nz || (emit_inc == length_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // held frame fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q    <= '0;
      length_q   <= '0;
      fill_q     <= '0;
      chk0_q     <= '0;
      chk1_q     <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.cap_ident) ident_q <= rx_byte_i;
      if (cmd_i.cap_len) begin
        fill_q <= '0;
        if (!sts_o.len_big) length_q <= rx_byte_i[LenW-1:0];
      end
      if (cmd_i.wr_data) fill_q <= fill_inc;
      if (cmd_i.cap_chk0) chk0_q <= rx_byte_i;
      if (cmd_i.cap_chk1) chk1_q <= rx_byte_i;
      if (cmd_i.emit_start) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_next) begin
        emit_idx_q <= emit_inc[IdxW-1:0];
      end
    end
  end

  // payload memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_data) mem_q[fill_q[AddrW-1:0]] <= rx_byte_i;
    if (cmd_i.rd_en) rd_data_q <= mem_q[emit_idx_q[AddrW-1:0]];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ident_q  <= ident_q;
      out_len_q    <= length_q;
      out_idx_q    <= emit_idx_q;
      out_byte_q   <= len_nz ? rd_data_q : '0;
      out_bvalid_q <= len_nz;
      out_chk0_q   <= chk0_q;
      out_chk1_q   <= chk1_q;
      out_last_q   <= sts_o.emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_ident_o    = out_ident_q;
  assign payload_length_o = out_len_q;
  assign byte_index_o     = out_idx_q;
  assign payload_byte_o   = out_byte_q;
  assign byte_valid_o     = out_bvalid_q;
  assign check_first_o    = out_chk0_q;
  assign check_second_o   = out_chk1_q;
  assign last_of_frame_o  = out_last_q;

endmodule

### rtl/sfr_ctrl.sv
`include "serial_frame_receiver_defines.svh"

module sfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  sfr_pkg::sfr_sts_t sts_i,
  output sfr_pkg::sfr_cmd_t cmd_o
);
  import sfr_pkg::*;

  typedef enum logic [3:0] {
    HEAD0,
    HEAD1,
    IDENT,
    LEN,
    DATA,
    CHK0,
    CHK1,
    TAIL0,
    TAIL1,
    EMIT_RD,
    EMIT_WR
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   acc;

  assign rx_ready_o = (state_q != EMIT_RD) && (state_q != EMIT_WR);
  assign acc        = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      HEAD0: begin
        if (acc && sts_i.head0_hit) state_d = HEAD1;
      end
      HEAD1: begin
        if (acc) state_d = sts_i.head1_hit ? IDENT : HEAD0;
      end
      IDENT: begin
        if (acc) begin
          cmd_o.cap_ident = 1'b1;
          state_d         = LEN;
        end
      end
      LEN: begin
        if (acc) begin
          cmd_o.cap_len = 1'b1;
          if (sts_i.len_big) begin
            state_d = HEAD0;
          end else if (sts_i.len_zero) begin
            state_d = CHK0;
          end else begin
            state_d = DATA;
          end
        end
      end
      DATA: begin
        if (acc) begin
          cmd_o.wr_data = 1'b1;
          if (sts_i.fill_done) state_d = CHK0;
        end
      end
      CHK0: begin
        if (acc) begin
          cmd_o.cap_chk0 = 1'b1;
          state_d        = CHK1;
        end
      end
      CHK1: begin
        if (acc) begin
          cmd_o.cap_chk1 = 1'b1;
          state_d        = TAIL0;
        end
      end
      TAIL0: begin
        if (acc) state_d = sts_i.tail0_hit ? TAIL1 : HEAD0;
      end
      TAIL1: begin
        if (acc) begin
          if (sts_i.tail1_hit) begin
            cmd_o.emit_start = 1'b1;
            state_d          = EMIT_RD;
          end else begin
            state_d = HEAD0;
          end
        end
      end
      EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = EMIT_WR;
      end
      EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.emit_last) begin
            state_d = HEAD0;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = EMIT_RD;
          end
        end
      end
      default: state_d = HEAD0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HEAD0;
    end else begin
      state_q <= state_d;
    end
  end

  `SFR_ASSERT_ALWAYS(a_rst_hunt, !rst_ni |=> state_q == HEAD0)
  `SFR_ASSERT(a_tail_emit, state_q == TAIL1 && acc && sts_i.tail1_hit |=> state_q == EMIT_RD)
  `SFR_ASSERT(a_rd_then_wr, state_q == EMIT_RD |=> state_q == EMIT_WR && !rx_ready_o)
  `SFR_ASSERT(a_last_hunt, cmd_o.load_out && sts_i.emit_last |=> state_q == HEAD0)

endmodule

### rtl/serial_frame_receiver.sv
// serial frame receiver: takes one received byte per request on the rx channel and hunts for
// frames of the form head_first, head_second, id, length, length payload bytes, two check bytes,
// tail_first, tail_second. the four framing bytes are set through the apb port (byte addresses
// 0, 4, 8 and 12, reset 0). a wrong header or tail byte, or a length above MAX_PAYLOAD, drops
// the frame and restarts the hunt. once the second tail byte matches, the frame drains as one
// request per payload byte on the output channel, each carrying id, length and the two check
// bytes (passed on unchecked), with last_of_frame on the final one; a zero-length frame gives a
// single request with byte_valid low. no rx byte is taken while a frame drains: each payload
// byte is read from the payload memory through its registered read and then loaded into the
// output register, which waits out any output stall. the last result may wait in the output
// register while the next frame is already being received.
module serial_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // received bytes
  input  logic                      rx_valid_i,
  output logic                      rx_ready_o,
  input  logic [sfr_pkg::ByteW-1:0] rx_byte_i,
  // frame payload
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sfr_pkg::ByteW-1:0] frame_ident_o,
  output logic [sfr_pkg::LenW-1:0]  payload_length_o,
  output logic [sfr_pkg::IdxW-1:0]  byte_index_o,
  output logic [sfr_pkg::ByteW-1:0] payload_byte_o,
  output logic                      byte_valid_o,
  output logic [sfr_pkg::ByteW-1:0] check_first_o,
  output logic [sfr_pkg::ByteW-1:0] check_second_o,
  output logic                      last_of_frame_o
);
  import sfr_pkg::*;

  // register map, word index from paddr[3:2]
  typedef enum logic [1:0] {
    REG_HEAD_FIRST  = 2'd0,
    REG_HEAD_SECOND = 2'd1,
    REG_TAIL_FIRST  = 2'd2,
    REG_TAIL_SECOND = 2'd3
  } reg_idx_e;

  sfr_cfg_t cfg_q;
  sfr_cmd_t cmd;
  sfr_sts_t sts;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  // register file: write in the access phase, the byte offset is ignored
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HEAD_FIRST:  cfg_q.head_first  <= pwdata[ByteW-1:0];
        REG_HEAD_SECOND: cfg_q.head_second <= pwdata[ByteW-1:0];
        REG_TAIL_FIRST:  cfg_q.tail_first  <= pwdata[ByteW-1:0];
        REG_TAIL_SECOND: cfg_q.tail_second <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero-extended
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_HEAD_FIRST:  prdata[ByteW-1:0] = cfg_q.head_first;
      REG_HEAD_SECOND: prdata[ByteW-1:0] = cfg_q.head_second;
      REG_TAIL_FIRST:  prdata[ByteW-1:0] = cfg_q.tail_first;
      REG_TAIL_SECOND: prdata[ByteW-1:0] = cfg_q.tail_second;
      default:         prdata = '0;
    endcase
  end

  // parse and drain sequencing
  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // byte compares, held fields, payload memory and output register
  sfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rx_byte_i        (rx_byte_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .frame_ident_o    (frame_ident_o),
    .payload_length_o (payload_length_o),
    .byte_index_o     (byte_index_o),
    .payload_byte_o   (payload_byte_o),
    .byte_valid_o     (byte_valid_o),
    .check_first_o    (check_first_o),
    .check_second_o   (check_second_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule
